### src/json_string_codepoint_counter_top_assert.svh
// Assertion macros for the JSON string character counter checker.
// Used by jscc_checker.sv; no other dependencies.
`ifndef JSON_STRING_CODEPOINT_COUNTER_TOP_ASSERT_SVH
`define JSON_STRING_CODEPOINT_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define JSCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define JSCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/jscc_pkg.sv
// Package for the JSON string character counter: window types, byte codes,
// decision record and the byte/hex helper functions. No dependencies.
`timescale 1ns / 1ps

package jscc_pkg;

    // Lookahead window geometry
    localparam int WIN_DEPTH = 12;
    localparam int FILL_W    = 4;
    localparam int INC_W     = 3;

    typedef logic [7:0]                    t_byte;
    typedef logic [FILL_W-1:0]             t_fill;
    typedef logic [INC_W-1:0]              t_inc;
    typedef logic [WIN_DEPTH-1:0][7:0]     t_win;

    // Byte codes
    localparam t_byte BYTE_BSLASH = 8'h5C;
    localparam t_byte BYTE_LOWER_U = 8'h75;
    localparam t_byte CONT_MASK   = 8'hC0;
    localparam t_byte CONT_TAG    = 8'h80;
    localparam t_byte CHAR_0      = 8'h30;
    localparam t_byte CHAR_9      = 8'h39;
    localparam t_byte CHAR_LA     = 8'h61;
    localparam t_byte CHAR_LF     = 8'h66;
    localparam t_byte CHAR_UA     = 8'h41;
    localparam t_byte CHAR_UF     = 8'h46;

    // Surrogate ranges
    localparam logic [15:0] SURR_HIGH_MIN = 16'hD800;
    localparam logic [15:0] SURR_HIGH_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LOW_MIN  = 16'hDC00;
    localparam logic [15:0] SURR_LOW_MAX  = 16'hDFFF;

    // Window fill levels with a fixed meaning
    localparam t_fill FILL_EMPTY   = 4'd0;  // nothing pending
    localparam t_fill FILL_ESC     = 4'd1;  // backslash held
    localparam t_fill FILL_U       = 4'd2;  // "\u" held
    localparam t_fill FILL_HI_END  = 4'd5;  // next byte completes first escape
    localparam t_fill FILL_PAIR_BS = 4'd6;  // high surrogate held, want '\'
    localparam t_fill FILL_PAIR_U  = 4'd7;  // want 'u' of second escape
    localparam t_fill FILL_LO      = 4'd8;  // first digit of second escape
    localparam t_fill FILL_LO_END  = 4'd11; // next byte completes second escape

    // Per-transaction decision
    typedef struct packed {
        t_inc  inc;     // characters decided by this byte
        t_fill fill;    // window fill afterwards
        logic  store;   // write the byte at the current fill position
        logic  shift6;  // drop the first escape, keep the second as new head
    } t_decision;

    // A byte counts unless it is a UTF-8 continuation byte
    function automatic logic is_counted(t_byte b);
        return (b & CONT_MASK) != CONT_TAG;
    endfunction

    // Four hex digits: {bad, value}
    function automatic logic [16:0] hex4(t_byte d0, t_byte d1, t_byte d2, t_byte d3);
        t_byte          c [4];
        logic [15:0]    v;
        logic [3:0]     nib;
        logic           bad;
        c[0] = d0;
        c[1] = d1;
        c[2] = d2;
        c[3] = d3;
        v    = '0;
        bad  = 1'b0;
        for (int k = 0; k < 4; k++) begin
            nib = 4'd0;
            if (c[k] >= CHAR_0 && c[k] <= CHAR_9) begin
                nib = c[k][3:0];
            end else if ((c[k] >= CHAR_LA && c[k] <= CHAR_LF) ||
                         (c[k] >= CHAR_UA && c[k] <= CHAR_UF)) begin
                nib = c[k][3:0] + 4'd9;
            end else begin
                bad = 1'b1;
            end
            v = {v[11:0], nib};
        end
        return {bad, v};
    endfunction

    function automatic logic is_high_surr(logic [16:0] h);
        return !h[16] && h[15:0] >= SURR_HIGH_MIN && h[15:0] <= SURR_HIGH_MAX;
    endfunction

    function automatic logic is_low_surr(logic [16:0] h);
        return !h[16] && h[15:0] >= SURR_LOW_MIN && h[15:0] <= SURR_LOW_MAX;
    endfunction

    // Characters in a tail of up to three bytes at end of string
    function automatic logic [1:0] tail_count(t_byte a0, t_byte a1, t_byte a2,
                                              logic [1:0] len);
        logic [1:0] n;
        n = 2'd0;
        if (len == 2'd0) begin
            n = 2'd0;
        end else if (a0 == BYTE_BSLASH && len >= 2'd2) begin
            // escape eats the next byte
            n = 2'd1 + ((len == 2'd3) ? {1'b0, is_counted(a2)} : 2'd0);
        end else begin
            n = {1'b0, is_counted(a0)};
            if (len >= 2'd2) begin
                if (a1 == BYTE_BSLASH && len == 2'd3) begin
                    n = n + 2'd1;
                end else begin
                    n = n + {1'b0, is_counted(a1)} +
                        ((len == 2'd3) ? {1'b0, is_counted(a2)} : 2'd0);
                end
            end
        end
        return n;
    endfunction

endpackage

### src/json_string_codepoint_counter_top.sv
// Top level of the JSON string character counter.
// Depends on jscc_pkg and jscc_decide.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one byte of a JSON string body
//   (quotes stripped) per transaction, i_last_byte marking the final byte.
//   Output channel (o_valid / i_ready) carries one transaction per string:
//   the character count (low 16 bits, saturating at 2^COUNT_WIDTH-1) and a
//   flag that is set when characters were dropped at saturation.
//   Throughput: one byte per cycle, sustained, strings back to back, unless a
//   last byte waits in the input register behind a stalled result.
//   Path: a byte is held in the input register, then the window logic decides
//   it; a string's result is registered once its last byte moves on.
//   The per-byte decision over the 12-byte lookahead window and the count
//   adder sit between the input register and the state/result registers.
//   Reset: control state, the count and the window fill clear; the block
//   accepts bytes in the first cycle after reset.
//   Receiver stall: the result is held while i_ready is low; bytes of the
//   next string keep flowing until its own last byte reaches the window logic,
//   which then waits, and o_ready drops until the result is taken.
`timescale 1ns / 1ps

module json_string_codepoint_counter_top #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_codepoint_count,
    output logic        o_count_saturated
);

    // Input register
    logic                r_in_valid;
    jscc_pkg::t_byte     r_in_byte;
    logic                r_in_last;

    // Window and count state
    jscc_pkg::t_win      r_win;
    jscc_pkg::t_fill     r_fill;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                r_sat;

    // Result register
    logic                r_out_valid;
    logic [15:0]         r_out_count;
    logic                r_out_sat;

    jscc_pkg::t_decision    dec;
    logic                   proceed;
    logic [COUNT_WIDTH:0]   sum;
    logic                   over;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   n_sat;

    // A byte moves on unless it ends a string and the result slot is busy
    assign proceed = r_in_valid && (!r_in_last || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || proceed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte_value;
            r_in_last <= i_last_byte;
        end
    end

    jscc_decide u_decide (
        .i_win  (r_win),
        .i_fill (r_fill),
        .i_byte (r_in_byte),
        .i_last (r_in_last),
        .o_dec  (dec)
    );

    // Saturating count update
    assign sum     = {1'b0, r_count} + (COUNT_WIDTH+1)'(dec.inc);
    assign over    = sum[COUNT_WIDTH];
    assign n_count = over ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    assign n_sat   = r_sat || over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= jscc_pkg::FILL_EMPTY;
            r_count <= '0;
            r_sat   <= 1'b0;
        end else if (proceed) begin
            if (r_in_last) begin
                r_fill  <= jscc_pkg::FILL_EMPTY;
                r_count <= '0;
                r_sat   <= 1'b0;
            end else begin
                r_fill  <= dec.fill;
                r_count <= n_count;
                r_sat   <= n_sat;
            end
        end
    end

    // Window storage, no reset: entries at or above the fill are never used
    always_ff @(posedge i_clk) begin
        if (proceed) begin
            if (dec.store) begin
                r_win[r_fill] <= r_in_byte;
            end
            if (dec.shift6) begin
                r_win[0] <= r_win[6];
                r_win[1] <= r_win[7];
                r_win[2] <= r_win[8];
                r_win[3] <= r_win[9];
                r_win[4] <= r_win[10];
                r_win[5] <= r_in_byte;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && r_in_last) begin
            r_out_count <= 16'(n_count);
            r_out_sat   <= n_sat;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_codepoint_count = r_out_count;
    assign o_count_saturated = r_out_sat;

endmodule

### src/jscc_decide.sv
// Per-byte decision logic: from the pending window, its fill, the new byte and
// the last flag, how many characters are decided and how the window moves.
// Depends on jscc_pkg.
`timescale 1ns / 1ps

module jscc_decide (
    input  jscc_pkg::t_win      i_win,
    input  jscc_pkg::t_fill     i_fill,
    input  jscc_pkg::t_byte     i_byte,
    input  logic                i_last,
    output jscc_pkg::t_decision o_dec
);

    jscc_pkg::t_byte a [jscc_pkg::WIN_DEPTH];
    logic [16:0]     hi;
    logic [16:0]     lo;
    logic [1:0]      tail_a;
    logic [1:0]      tail_b;

    // Window with the new byte placed at the fill position
    always_comb begin
        for (int i = 0; i < jscc_pkg::WIN_DEPTH; i++) begin
            a[i] = (jscc_pkg::FILL_W'(i) == i_fill) ? i_byte : i_win[i];
        end
    end

    assign hi = jscc_pkg::hex4(a[2], a[3], a[4], a[5]);
    assign lo = jscc_pkg::hex4(a[8], a[9], a[10], a[11]);

    // Tails rescanned at end of string
    assign tail_a = jscc_pkg::tail_count(a[2], a[3], a[4], 2'(i_fill - 4'd1));
    assign tail_b = jscc_pkg::tail_count(a[8], a[9], a[10], 2'(i_fill - 4'd7));

    always_comb begin
        o_dec = '0;
        if (!i_last) begin
            // mid-string: decide what is complete, hold the rest
            case (i_fill) inside
                jscc_pkg::FILL_EMPTY: begin
                    if (i_byte == jscc_pkg::BYTE_BSLASH) begin
                        o_dec.store = 1'b1;
                        o_dec.fill  = jscc_pkg::FILL_ESC;
                    end else begin
                        o_dec.inc = {2'b00, jscc_pkg::is_counted(i_byte)};
                    end
                end
                jscc_pkg::FILL_ESC: begin
                    if (i_byte == jscc_pkg::BYTE_LOWER_U) begin
                        o_dec.store = 1'b1;
                        o_dec.fill  = jscc_pkg::FILL_U;
                    end else begin
                        o_dec.inc = 3'd1;
                    end
                end
                [jscc_pkg::FILL_U : jscc_pkg::FILL_HI_END - 4'd1],
                [jscc_pkg::FILL_LO : jscc_pkg::FILL_LO_END - 4'd1]: begin
                    o_dec.store = 1'b1;
                    o_dec.fill  = i_fill + 4'd1;
                end
                jscc_pkg::FILL_HI_END: begin
                    if (jscc_pkg::is_high_surr(hi)) begin
                        o_dec.store = 1'b1;
                        o_dec.fill  = jscc_pkg::FILL_PAIR_BS;
                    end else begin
                        o_dec.inc = 3'd1;
                    end
                end
                jscc_pkg::FILL_PAIR_BS: begin
                    if (i_byte == jscc_pkg::BYTE_BSLASH) begin
                        o_dec.store = 1'b1;
                        o_dec.fill  = jscc_pkg::FILL_PAIR_U;
                    end else begin
                        o_dec.inc = 3'd1 + {2'b00, jscc_pkg::is_counted(i_byte)};
                    end
                end
                jscc_pkg::FILL_PAIR_U: begin
                    if (i_byte == jscc_pkg::BYTE_LOWER_U) begin
                        o_dec.store = 1'b1;
                        o_dec.fill  = jscc_pkg::FILL_LO;
                    end else begin
                        o_dec.inc = 3'd2;
                    end
                end
                jscc_pkg::FILL_LO_END: begin
                    if (jscc_pkg::is_low_surr(lo)) begin
                        o_dec.inc = 3'd1;
                    end else if (jscc_pkg::is_high_surr(lo)) begin
                        // second escape becomes the new pending head
                        o_dec.inc    = 3'd1;
                        o_dec.shift6 = 1'b1;
                        o_dec.fill   = jscc_pkg::FILL_PAIR_BS;
                    end else begin
                        o_dec.inc = 3'd2;
                    end
                end
                default: begin
                    o_dec = '0;
                end
            endcase
        end else begin
            // end of string: flush everything pending
            case (i_fill) inside
                jscc_pkg::FILL_EMPTY: begin
                    o_dec.inc = {2'b00, jscc_pkg::is_counted(i_byte)};
                end
                jscc_pkg::FILL_ESC, jscc_pkg::FILL_HI_END: begin
                    o_dec.inc = 3'd1;
                end
                [jscc_pkg::FILL_U : jscc_pkg::FILL_HI_END - 4'd1]: begin
                    o_dec.inc = 3'd1 + {1'b0, tail_a};
                end
                jscc_pkg::FILL_PAIR_BS: begin
                    o_dec.inc = 3'd1 + {2'b00, jscc_pkg::is_counted(i_byte)};
                end
                jscc_pkg::FILL_PAIR_U: begin
                    o_dec.inc = 3'd2;
                end
                [jscc_pkg::FILL_LO : jscc_pkg::FILL_LO_END - 4'd1]: begin
                    o_dec.inc = 3'd2 + {1'b0, tail_b};
                end
                jscc_pkg::FILL_LO_END: begin
                    o_dec.inc = jscc_pkg::is_low_surr(lo) ? 3'd1 : 3'd2;
                end
                default: begin
                    o_dec = '0;
                end
            endcase
        end
    end

endmodule

### src/jscc_checker.sv
// Port-level checker for the JSON string character counter, bound to the top.
// Depends on json_string_codepoint_counter_top_assert.svh.
`timescale 1ns / 1ps
`include "json_string_codepoint_counter_top_assert.svh"

module jscc_checker #(
    parameter int COUNT_WIDTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_byte_value,
    input logic        i_last_byte,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_codepoint_count,
    input logic        o_count_saturated
);

    // Low 16 bits of the saturated count
    localparam logic [15:0] SAT_VALUE = 16'((64'd1 << COUNT_WIDTH) - 64'd1);

    // A stalled result transaction holds
    `JSCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_codepoint_count) && $stable(o_count_saturated),
        "result changed while stalled")
    // A stalled byte transaction holds
    `JSCC_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && !o_ready,
        i_valid && $stable(i_byte_value) && $stable(i_last_byte),
        "input changed while stalled")
    // Input side only backs up behind a stalled result
    `JSCC_ASSERT_NOW(a_backpressure, i_clk, i_rst_n, !o_ready, o_valid && !i_ready,
        "input stalled without output stall")
    // A saturated result shows the maximum count
    `JSCC_ASSERT_NOW(a_sat_value, i_clk, i_rst_n, o_valid && o_count_saturated,
        o_codepoint_count == SAT_VALUE, "saturated count not at maximum")
    // Reset leaves an empty block that takes bytes
    `JSCC_ASSERT_NEXT(a_reset, i_clk, 1'b1, !i_rst_n, !o_valid && o_ready,
        "state after reset")

endmodule

bind json_string_codepoint_counter_top jscc_checker #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_jscc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .i_byte_value      (i_byte_value),
    .i_last_byte       (i_last_byte),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_codepoint_count (o_codepoint_count),
    .o_count_saturated (o_count_saturated)
);

### dv/tb_json_string_codepoint_counter_top.sv
// Self-checking testbench for json_string_codepoint_counter_top.
// Uses jscc_pkg for byte codes and surrogate bounds. It keeps its own character
// counting model, runs directed and random JSON string bodies under several
// idle and stall patterns, and checks every count transaction.
`timescale 1ns / 1ps

module tb_json_string_codepoint_counter_top;

    localparam int          COUNT_WIDTH  = 16;
    localparam longint      CHAR_LIMIT   = (64'd1 << COUNT_WIDTH) - 1;
    localparam int          NOT_HEX      = 16;
    localparam int          BAD_ESCAPE   = 32'h10000;
    localparam int          SHORT_ESC    = 2;   // backslash plus one byte
    localparam int          U_ESC        = 6;   // \uXXXX
    localparam int          PAIR_ESC     = 12;  // \uXXXX\uXXXX
    localparam int          HOLD_CYCLES  = 400;
    localparam int          QUIET_LIMIT  = 5000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          N_DIRECTED   = 23;

    typedef struct packed {
        logic [15:0] count;
        logic        sat;
    } t_count_result;

    typedef struct packed {
        jscc_pkg::t_byte value;
        logic            last;
        logic            typed;   // expected count typed in below
        logic [15:0]     count;
        logic            sat;
    } t_directed_row;

    typedef enum int {
        TOK_ASCII, TOK_UTF8, TOK_SIMPLE_ESC, TOK_BMP_ESC, TOK_PAIR,
        TOK_BROKEN_PAIR, TOK_BAD_HEX, TOK_NOISE
    } t_token;

    typedef enum int {
        TAIL_BSLASH, TAIL_U, TAIL_U_PART, TAIL_HIGH, TAIL_HIGH_BS, TAIL_HIGH_LOW_PART
    } t_tail;

    // Directed strings, one byte per row
    localparam t_directed_row DIRECTED_ROWS [N_DIRECTED] = '{
        // single bytes: plain, extremes, lone continuation
        '{8'h41, 1'b1, 1'b1, 16'd1, 1'b0},
        '{8'h00, 1'b1, 1'b1, 16'd1, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 16'd1, 1'b0},
        '{8'h80, 1'b1, 1'b1, 16'd0, 1'b0},
        // lone trailing backslash
        '{jscc_pkg::BYTE_BSLASH, 1'b1, 1'b1, 16'd1, 1'b0},
        // escape swallows a continuation byte
        '{jscc_pkg::BYTE_BSLASH, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h80, 1'b1, 1'b1, 16'd1, 1'b0},
        // \u cut short by end of string: "\u" then "1"
        '{jscc_pkg::BYTE_BSLASH, 1'b0, 1'b0, 16'd0, 1'b0},
        '{jscc_pkg::BYTE_LOWER_U, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h31, 1'b1, 1'b1, 16'd2, 1'b0},
        // bad hex digit: \u12G4
        '{jscc_pkg::BYTE_BSLASH, 1'b0, 1'b0, 16'd0, 1'b0},
        '{jscc_pkg::BYTE_LOWER_U, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h31, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h32, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h47, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h34, 1'b1, 1'b1, 16'd1, 1'b0},
        // broken pair: \uD83D then 'x', left to the model
        '{jscc_pkg::BYTE_BSLASH, 1'b0, 1'b0, 16'd0, 1'b0},
        '{jscc_pkg::BYTE_LOWER_U, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h44, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h38, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h33, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h44, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h78, 1'b1, 1'b0, 16'd0, 1'b0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_byte_value;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_codepoint_count;
    logic        o_count_saturated;

    // Counting model state
    jscc_pkg::t_byte pend_bytes [jscc_pkg::WIN_DEPTH];
    int unsigned     pend_len;
    longint unsigned char_total;
    bit              chars_dropped;

    t_count_result   expected_counts [$];
    jscc_pkg::t_byte body_bytes [$];

    int unsigned     valid_idle_pct;
    int unsigned     ready_stall_pct;
    bit              hold_request;
    int unsigned     hold_left;
    int unsigned     mismatch_count;
    int unsigned     bytes_sent;
    int unsigned     strings_sent;
    int unsigned     results_checked;
    int unsigned     saturated_seen;
    int unsigned     quiet_cycles;

    json_string_codepoint_counter_top #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_byte_value      (i_byte_value),
        .i_last_byte       (i_last_byte),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_codepoint_count (o_codepoint_count),
        .o_count_saturated (o_count_saturated)
    );

    // ------------------------------------------------------------------
    // Counting model
    // ------------------------------------------------------------------

    function automatic void add_char();
        if (char_total >= CHAR_LIMIT) begin
            chars_dropped = 1'b1;
        end else begin
            char_total++;
        end
    endfunction

    function automatic void drop_front(int unsigned k);
        if (k > pend_len) begin
            k = pend_len;
        end
        for (int i = 0; i < jscc_pkg::WIN_DEPTH; i++) begin
            pend_bytes[i] = (i + k < jscc_pkg::WIN_DEPTH) ? pend_bytes[i + k] : 8'h00;
        end
        pend_len -= k;
    endfunction

    function automatic int unsigned hex_nibble(jscc_pkg::t_byte c);
        if (c >= jscc_pkg::CHAR_0 && c <= jscc_pkg::CHAR_9) return c - jscc_pkg::CHAR_0;
        if (c >= jscc_pkg::CHAR_LA && c <= jscc_pkg::CHAR_LF) return c - jscc_pkg::CHAR_LA + 10;
        if (c >= jscc_pkg::CHAR_UA && c <= jscc_pkg::CHAR_UF) return c - jscc_pkg::CHAR_UA + 10;
        return NOT_HEX;
    endfunction

    // value of the four hex digits at pos, BAD_ESCAPE if any is not hex
    function automatic int unsigned escape_value(int unsigned pos);
        int unsigned v;
        int unsigned d;
        v = 0;
        for (int k = 0; k < 4; k++) begin
            d = hex_nibble(pend_bytes[pos + k]);
            if (d == NOT_HEX) return BAD_ESCAPE;
            v = (v << 4) | d;
        end
        return v;
    endfunction

    // Resolve the byte at the head of the window; 0 if more bytes are needed
    function automatic bit settle_head(bit at_end);
        jscc_pkg::t_byte head;
        int unsigned     hi;
        int unsigned     lo;
        head = pend_bytes[0];
        if (head != jscc_pkg::BYTE_BSLASH) begin
            if ((head & jscc_pkg::CONT_MASK) != jscc_pkg::CONT_TAG) add_char();
            drop_front(1);
            return 1'b1;
        end
        if (pend_len < SHORT_ESC) begin
            if (!at_end) return 1'b0;
            add_char();
            drop_front(1);
            return 1'b1;
        end
        if (pend_bytes[1] != jscc_pkg::BYTE_LOWER_U) begin
            add_char();
            drop_front(SHORT_ESC);
            return 1'b1;
        end
        if (pend_len < U_ESC) begin
            if (!at_end) return 1'b0;
            add_char();
            drop_front(SHORT_ESC);
            return 1'b1;
        end
        hi = escape_value(2);
        if (hi < jscc_pkg::SURR_HIGH_MIN || hi > jscc_pkg::SURR_HIGH_MAX ||
            (pend_len > U_ESC && pend_bytes[U_ESC] != jscc_pkg::BYTE_BSLASH) ||
            (pend_len > U_ESC + 1 &&
             pend_bytes[U_ESC + 1] != jscc_pkg::BYTE_LOWER_U)) begin
            add_char();
            drop_front(U_ESC);
            return 1'b1;
        end
        if (pend_len < PAIR_ESC) begin
            if (!at_end) return 1'b0;
            add_char();
            drop_front(U_ESC);
            return 1'b1;
        end
        lo = escape_value(U_ESC + 2);
        add_char();
        drop_front((lo >= jscc_pkg::SURR_LOW_MIN && lo <= jscc_pkg::SURR_LOW_MAX) ?
                   PAIR_ESC : U_ESC);
        return 1'b1;
    endfunction

    // One accepted byte; returns 1 with the count when the string ends
    function automatic bit model_byte(input jscc_pkg::t_byte b, input logic last,
                                      output t_count_result res);
        res = '0;
        if (pend_len < jscc_pkg::WIN_DEPTH) begin
            pend_bytes[pend_len] = b;
            pend_len++;
        end
        while (pend_len > 0 && settle_head(last)) begin
        end
        if (!last) return 1'b0;
        res.count     = char_total[15:0];
        res.sat       = chars_dropped;
        char_total    = 0;
        chars_dropped = 1'b0;
        pend_len      = 0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // String body generation
    // ------------------------------------------------------------------

    function automatic jscc_pkg::t_byte plain_byte();
        jscc_pkg::t_byte v;
        do begin
            v = jscc_pkg::t_byte'($urandom_range(8'h20, 8'h7E));
        end while (v == jscc_pkg::BYTE_BSLASH);
        return v;
    endfunction

    function automatic jscc_pkg::t_byte cont_byte();
        return jscc_pkg::CONT_TAG | jscc_pkg::t_byte'($urandom_range(0, 63));
    endfunction

    function automatic jscc_pkg::t_byte hex_char(logic [3:0] n);
        if (n < 10) return jscc_pkg::CHAR_0 + jscc_pkg::t_byte'(n);
        return ($urandom_range(0, 1) ? jscc_pkg::CHAR_UA : jscc_pkg::CHAR_LA) +
               jscc_pkg::t_byte'(n) - 8'd10;
    endfunction

    function automatic jscc_pkg::t_byte non_hex_byte();
        jscc_pkg::t_byte v;
        do begin
            v = jscc_pkg::t_byte'($urandom_range(0, 255));
        end while (hex_nibble(v) != NOT_HEX);
        return v;
    endfunction

    function automatic int unsigned high_surr();
        return jscc_pkg::SURR_HIGH_MIN + $urandom_range(0, 10'h3FF);
    endfunction

    // \u plus the first n_digits hex digits of v
    function automatic void push_u_escape(int unsigned v, int unsigned n_digits);
        body_bytes.push_back(jscc_pkg::BYTE_BSLASH);
        body_bytes.push_back(jscc_pkg::BYTE_LOWER_U);
        for (int k = 0; k < n_digits; k++) begin
            body_bytes.push_back(hex_char(4'((v >> (12 - 4 * k)) & 32'hF)));
        end
    endfunction

    function automatic void append_token(t_token kind);
        int unsigned v;
        int unsigned bad_pos;
        case (kind)
            TOK_ASCII: begin
                body_bytes.push_back(plain_byte());
            end
            TOK_UTF8: begin
                v = $urandom_range(1, 3);
                case (v)
                    1: body_bytes.push_back(jscc_pkg::t_byte'($urandom_range(8'hC2, 8'hDF)));
                    2: body_bytes.push_back(jscc_pkg::t_byte'($urandom_range(8'hE0, 8'hEF)));
                    default: begin
                        body_bytes.push_back(jscc_pkg::t_byte'($urandom_range(8'hF0, 8'hF4)));
                    end
                endcase
                repeat (v) body_bytes.push_back(cont_byte());
            end
            TOK_SIMPLE_ESC: begin
                // any escaped byte but 'u', continuation bytes included
                body_bytes.push_back(jscc_pkg::BYTE_BSLASH);
                v = $urandom_range(0, 255);
                body_bytes.push_back((jscc_pkg::t_byte'(v) == jscc_pkg::BYTE_LOWER_U) ?
                                     jscc_pkg::BYTE_BSLASH : jscc_pkg::t_byte'(v));
            end
            TOK_BMP_ESC: begin
                push_u_escape($urandom_range(0, 16'hFFFF), 4);
            end
            TOK_PAIR: begin
                push_u_escape(high_surr(), 4);
                push_u_escape(jscc_pkg::SURR_LOW_MIN + $urandom_range(0, 10'h3FF), 4);
            end
            TOK_BROKEN_PAIR: begin
                push_u_escape(high_surr(), 4);
                case ($urandom_range(0, 3))
                    0:       body_bytes.push_back(plain_byte());
                    1:       push_u_escape($urandom_range(0, jscc_pkg::SURR_LOW_MIN - 1), 4);
                    2:       append_token(TOK_SIMPLE_ESC);
                    default: append_token(TOK_BAD_HEX);
                endcase
            end
            TOK_BAD_HEX: begin
                bad_pos = $urandom_range(0, 3);
                body_bytes.push_back(jscc_pkg::BYTE_BSLASH);
                body_bytes.push_back(jscc_pkg::BYTE_LOWER_U);
                for (int k = 0; k < 4; k++) begin
                    body_bytes.push_back((k == bad_pos) ? non_hex_byte()
                                                        : hex_char(4'($urandom_range(0, 15))));
                end
            end
            default: begin
                // escape-heavy noise
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 3))
                        0:       body_bytes.push_back(jscc_pkg::BYTE_BSLASH);
                        1:       body_bytes.push_back(jscc_pkg::BYTE_LOWER_U);
                        default: body_bytes.push_back(jscc_pkg::t_byte'($urandom_range(0, 255)));
                    endcase
                end
            end
        endcase
    endfunction

    // Escapes cut short by the end of the string
    function automatic void append_tail(t_tail kind);
        case (kind)
            TAIL_BSLASH: body_bytes.push_back(jscc_pkg::BYTE_BSLASH);
            TAIL_U:      push_u_escape(0, 0);
            TAIL_U_PART: push_u_escape($urandom_range(0, 16'hFFFF), $urandom_range(1, 3));
            TAIL_HIGH:   push_u_escape(high_surr(), 4);
            TAIL_HIGH_BS: begin
                push_u_escape(high_surr(), 4);
                body_bytes.push_back(jscc_pkg::BYTE_BSLASH);
            end
            default: begin
                push_u_escape(high_surr(), 4);
                push_u_escape(jscc_pkg::SURR_LOW_MIN + $urandom_range(0, 10'h3FF),
                              $urandom_range(0, 3));
            end
        endcase
    endfunction

    function automatic void build_body();
        bit noisy;
        body_bytes.delete();
        noisy = ($urandom_range(0, 99) < 20);
        repeat ($urandom_range(1, 4)) begin
            if (noisy) begin
                append_token(t_token'($urandom_range(0, TOK_NOISE)));
            end else begin
                append_token(t_token'($urandom_range(0, TOK_BAD_HEX)));
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            append_tail(t_tail'($urandom_range(0, TAIL_HIGH_LOW_PART)));
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one byte, wait for the transaction, then update the model
    task automatic send_byte(input jscc_pkg::t_byte b, input logic last,
                             input logic use_typed, input t_count_result typed_res);
        t_count_result res;
        while ($urandom_range(0, 99) < valid_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_byte_value <= b;
        i_last_byte  <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
        if (model_byte(b, last, res)) begin
            expected_counts.push_back(use_typed ? typed_res : res);
            strings_sent++;
        end
    endtask

    task automatic send_body();
        for (int i = 0; i < body_bytes.size(); i++) begin
            send_byte(body_bytes[i], i == body_bytes.size() - 1, 1'b0, '0);
        end
    endtask

    task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct,
                             int unsigned n_bytes);
        int unsigned start;
        valid_idle_pct  = idle_pct;
        ready_stall_pct = stall_pct;
        start           = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            build_body();
            send_body();
        end
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Result side: stall pattern, long hold-off, and count check
    // ------------------------------------------------------------------
    initial begin
        t_count_result want;
        i_ready   <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                results_checked++;
                if (o_count_saturated) saturated_seen++;
                if (expected_counts.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected count transaction, count %0d sat %0b",
                             $time, o_codepoint_count, o_count_saturated);
                end else begin
                    want = expected_counts.pop_front();
                    if (o_codepoint_count !== want.count) begin
                        mismatch_count++;
                        $display("%0t: codepoint_count expected %0d actual %0d",
                                 $time, want.count, o_codepoint_count);
                    end
                    if (o_count_saturated !== want.sat) begin
                        mismatch_count++;
                        $display("%0t: count_saturated expected %0b actual %0b",
                                 $time, want.sat, o_count_saturated);
                    end
                end
            end
            if (hold_request && hold_left == 0) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no transaction on either channel
    // ------------------------------------------------------------------
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("json_string_codepoint_counter_top regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_count_result typed;
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_byte_value    <= '0;
        i_last_byte     <= 1'b0;
        valid_idle_pct  = 0;
        ready_stall_pct = 0;
        hold_request    = 1'b0;
        mismatch_count  = 0;
        bytes_sent      = 0;
        strings_sent    = 0;
        results_checked = 0;
        saturated_seen  = 0;
        pend_bytes      = '{default: 8'h00};
        pend_len        = 0;
        char_total      = 0;
        chars_dropped   = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed strings
        for (int r = 0; r < N_DIRECTED; r++) begin
            typed.count = DIRECTED_ROWS[r].count;
            typed.sat   = DIRECTED_ROWS[r].sat;
            send_byte(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].last,
                      DIRECTED_ROWS[r].typed, typed);
        end

        // random strings under each idle pattern
        run_phase(0, 0, 120);
        run_phase(55, 0, 120);
        run_phase(0, 55, 120);
        run_phase(13, 13, 120);

        // long receiver hold-off while bytes keep coming
        hold_request = 1'b1;
        run_phase(0, 0, 100);

        i_valid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d strings; %0d counts checked, %0d saturated.",
                 bytes_sent, strings_sent, results_checked, saturated_seen);
        $display("Mismatches: %0d", mismatch_count);
        if (mismatch_count == 0) begin
            $display("json_string_codepoint_counter_top regression: pass");
        end else begin
            $display("json_string_codepoint_counter_top regression: fail");
        end
        $finish;
    end

endmodule
